>>> design/pcmc_pkg.sv
// ============================================================================
// pcmc_pkg: shared types and constants for the magazine handle cache
// Widths, status codes and the slot memory request bundle.
// ============================================================================
package pcmc_pkg;
  localparam int unsigned Cpus       = 2;
  localparam int unsigned MagDepth   = 64;
  localparam int unsigned PoolMags   = 32;
  localparam int unsigned FullDepth  = 32;
  localparam int unsigned EmptyDepth = 16;

  localparam int unsigned MagW   = $clog2(PoolMags);
  localparam int unsigned SlotW  = $clog2(MagDepth);
  localparam int unsigned FillW  = SlotW + 1;
  localparam int unsigned AddrW  = MagW + SlotW;
  localparam int unsigned FcntW  = $clog2(FullDepth + 1);
  localparam int unsigned EcntW  = $clog2(EmptyDepth + 1);
  localparam int unsigned FidxW  = $clog2(FullDepth);
  localparam int unsigned EidxW  = $clog2(EmptyDepth);
  localparam int unsigned PoolW  = $clog2(PoolMags + 1);
  localparam int unsigned CpuW   = 1;
  localparam int unsigned DataW  = 64;

  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_GOT       = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FETCH     = 3'd3,
    ST_FLUSHED   = 3'd4,
    ST_POOL_OUT  = 3'd5,
    ST_FREE_FULL = 3'd6
  } status_e;

  localparam logic OP_PUT = 1'b0;
  localparam logic OP_GET = 1'b1;

  // one slot memory access
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] wdata;
  } mem_req_t;
endpackage

>>> design/per_cpu_magazine_handle_cache.sv
// ============================================================================
// per_cpu_magazine_handle_cache: per-CPU magazine cache of 64-bit handles
// Top level: sequencer, magazine bookkeeping and the slot memory.
// ============================================================================
// Usage:
//  s_axis carries one request: tdata = {must_get, handle, cpu, operation}
//  (operation in bit 0), padded to 72 bits. m_axis returns results:
//  tdata = {item, status} padded to 72 bits, tlast on the final result.
//  cfg_valid_i/cfg_ready_o write size_limit (7 bits), only while idle.
// Sequence: one request is taken at a time. A put or get that hits its
//  current magazine goes from decide (S_DEC) to S_OUT or S_RD (slot
//  memory access into the result register), then waits in S_WAIT and
//  returns to S_IDLE before the next request is taken. Miss and error
//  results are set straight from S_DEC. A swap costs nothing extra; a
//  depot walk on a get adds a pass through S_DEC for each depot magazine
//  tried. A flushing put reads out its stored handles one result per
//  handle, alternating S_FLRD and S_FLOUT, set by the single read/write
//  port of the slot memory.
// Reset: all magazines, stacks and pool pointer clear at once; size_limit
//  returns to 64. Slot memory contents are not cleared.
// Stall: a result waits in the output register while m_axis_tready is low;
//  the sequencer holds until it is taken.
// ============================================================================
module per_cpu_magazine_handle_cache (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation[0], cpu[1], handle[65:2], must_get[66], zero[71:67]
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], item[66:3], zero[71:67]
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i
);
  import pcmc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_OUT   = 3'd3;
  localparam logic [2:0] S_FLRD  = 3'd4;
  localparam logic [2:0] S_FLOUT = 3'd5;
  localparam logic [2:0] S_WAIT  = 3'd6;

  logic [2:0] state_q, state_d;

  // request latches
  logic             op_q;
  logic [CpuW-1:0]  cpu_q;
  logic [DataW-1:0] hnd_q;
  logic             must_q;

  // bookkeeping
  logic [FillW-1:0] fill_q [PoolMags];
  logic [PoolW-1:0] pool_q;
  logic [MagW-1:0]  cur_q [Cpus];
  logic [MagW-1:0]  prev_q [Cpus];
  logic [Cpus-1:0]  curv_q, prevv_q;
  logic [MagW-1:0]  fstk_q [FullDepth];
  logic [FcntW-1:0] fcnt_q;
  logic [MagW-1:0]  estk_q [EmptyDepth];
  logic [EcntW-1:0] ecnt_q;
  logic [6:0]       lim_q;

  // flush walk
  logic [MagW-1:0]  fmag_q;
  logic [FillW-1:0] fidx_q, fcnt_walk_q;

  // output register
  logic             ov_q;
  logic [2:0]       ost_q;
  logic [DataW-1:0] oitem_q;
  logic             olast_q;

  mem_req_t         req;
  logic [DataW-1:0] rdata;

  pcmc_ram #(.Width(DataW), .Depth(PoolMags * MagDepth)) u_slots (
    .clk_i  (clk_i),
    .we_i   (req.we),
    .addr_i (req.addr),
    .wdata_i(req.wdata),
    .rdata_o(rdata)
  );

  // clamped limit
  logic [FillW-1:0] lim;
  always_comb begin
    if (lim_q == 7'd0) begin
      lim = FillW'(1);
    end else if (32'(lim_q) > MagDepth) begin
      lim = FillW'(MagDepth);
    end else begin
      lim = FillW'(lim_q);
    end
  end

  // views of the requesting CPU
  logic [MagW-1:0]  cur_m, prev_m, top_m;
  logic             cur_v, prev_v;
  logic [FillW-1:0] cur_f, prev_f;
  always_comb begin
    cur_m  = cur_q[cpu_q];
    prev_m = prev_q[cpu_q];
    cur_v  = curv_q[cpu_q];
    prev_v = prevv_q[cpu_q];
    cur_f  = fill_q[cur_m];
    prev_f = fill_q[prev_m];
    top_m  = fstk_q[FidxW'(fcnt_q - FcntW'(1))];
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = (state_q == S_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {5'd0, oitem_q, ost_q};

  logic out_free;
  assign out_free = !ov_q || m_axis_tready;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pool_q     <= '0;
      curv_q     <= '0;
      prevv_q    <= '0;
      fcnt_q     <= '0;
      ecnt_q     <= '0;
      lim_q      <= 7'd64;
      ov_q       <= 1'b0;
      for (int i = 0; i < PoolMags; i++) fill_q[i] <= '0;
      for (int i = 0; i < Cpus; i++) begin
        cur_q[i]  <= '0;
        prev_q[i] <= '0;
      end
    end else begin
      if (ov_q && m_axis_tready) begin
        ov_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        lim_q <= cfg_data_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op_q   <= s_axis_tdata[0];
            cpu_q  <= s_axis_tdata[1];
            hnd_q  <= s_axis_tdata[65:2];
            must_q <= s_axis_tdata[66];
            state_q <= S_DEC;
          end
        end
        S_DEC: begin
          if (out_free) begin
            ost_q      <= ST_STORED;
            oitem_q    <= '0;
            olast_q    <= 1'b1;
            if (op_q == OP_PUT) begin
              if (cur_v && cur_f < lim) begin
                fill_q[cur_m] <= cur_f + FillW'(1);
                state_q <= S_OUT;
              end else if (prev_v && prev_f == '0) begin
                cur_q[cpu_q]  <= prev_m;  prev_q[cpu_q]  <= cur_m;
                curv_q[cpu_q] <= 1'b1;    prevv_q[cpu_q] <= cur_v;
                fill_q[prev_m] <= FillW'(1);
                state_q <= S_OUT;
              end else if (32'(fcnt_q) < FullDepth) begin
                if (ecnt_q != '0) begin
                  ecnt_q <= ecnt_q - EcntW'(1);
                  cur_q[cpu_q] <= estk_q[EidxW'(ecnt_q - EcntW'(1))];
                  fill_q[estk_q[EidxW'(ecnt_q - EcntW'(1))]] <=
                    fill_q[estk_q[EidxW'(ecnt_q - EcntW'(1))]] + FillW'(1);
                  if (cur_v) begin
                    fstk_q[FidxW'(fcnt_q)] <= cur_m;
                    fcnt_q <= fcnt_q + FcntW'(1);
                  end
                  curv_q[cpu_q] <= 1'b1;
                  state_q <= S_OUT;
                end else if (32'(pool_q) < PoolMags) begin
                  pool_q <= pool_q + PoolW'(1);
                  cur_q[cpu_q] <= MagW'(pool_q);
                  fill_q[MagW'(pool_q)] <= FillW'(1);
                  if (cur_v) begin
                    fstk_q[FidxW'(fcnt_q)] <= cur_m;
                    fcnt_q <= fcnt_q + FcntW'(1);
                  end
                  curv_q[cpu_q] <= 1'b1;
                  state_q <= S_OUT;
                end else begin
                  ost_q <= ST_POOL_OUT;
                  ov_q <= 1'b1;
                  state_q <= S_WAIT;
                end
              end else if (!cur_v) begin
                ost_q   <= ST_FLUSHED;
                oitem_q <= hnd_q;
                ov_q    <= 1'b1;
                state_q <= S_WAIT;
              end else if (cur_f == '0) begin
                fill_q[cur_m] <= FillW'(1);
                state_q <= S_OUT;
              end else begin
                fmag_q      <= cur_m;
                fidx_q      <= '0;
                fcnt_walk_q <= cur_f;
                state_q     <= S_FLRD;
              end
            end else begin
              if (cur_v && cur_f != '0) begin
                fill_q[cur_m] <= cur_f - FillW'(1);
                ost_q <= ST_GOT;
                state_q <= S_RD;
              end else if (prev_v && prev_f != '0) begin
                cur_q[cpu_q]  <= prev_m;  prev_q[cpu_q]  <= cur_m;
                curv_q[cpu_q] <= 1'b1;    prevv_q[cpu_q] <= cur_v;
                fill_q[prev_m] <= prev_f - FillW'(1);
                ost_q <= ST_GOT;
                state_q <= S_RD;
              end else if (fcnt_q != '0) begin
                if (cur_v && 32'(ecnt_q) >= EmptyDepth) begin
                  ost_q <= ST_FREE_FULL; ov_q <= 1'b1;
                  state_q <= S_WAIT;
                end else begin
                  if (cur_v) begin
                    estk_q[EidxW'(ecnt_q)] <= cur_m;
                    ecnt_q <= ecnt_q + EcntW'(1);
                  end
                  fcnt_q <= fcnt_q - FcntW'(1);
                  cur_q[cpu_q]  <= top_m;
                  curv_q[cpu_q] <= 1'b1;
                  // re-evaluate next cycle on the new current
                  state_q <= S_DEC;
                end
              end else begin
                ost_q <= must_q ? ST_FETCH : ST_EMPTY;
                ov_q <= 1'b1;
                state_q <= S_WAIT;
              end
            end
          end
        end
        S_RD: begin
          oitem_q <= rdata;
          ov_q <= 1'b1;
          state_q <= S_WAIT;
        end
        S_OUT: begin
          ov_q <= 1'b1;
          state_q <= S_WAIT;
        end
        S_FLRD: begin
          if (out_free) begin
            state_q <= S_FLOUT;
          end
        end
        S_FLOUT: begin
          ost_q      <= ST_FLUSHED;
          oitem_q    <= rdata;
          olast_q    <= (fidx_q + FillW'(1) == fcnt_walk_q);
          ov_q       <= 1'b1;
          fidx_q     <= fidx_q + FillW'(1);
          if (fidx_q + FillW'(1) == fcnt_walk_q) begin
            fill_q[fmag_q] <= FillW'(1);
            state_q <= S_WAIT;
          end else begin
            state_q <= S_FLRD;
          end
        end
        S_WAIT: begin
          if (!ov_q || m_axis_tready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // slot memory access for the current step
  always_comb begin
    req.we    = 1'b0;
    req.addr  = {cur_m, cur_f[SlotW-1:0]};
    req.wdata = hnd_q;
    if (state_q == S_DEC && out_free && op_q == OP_PUT) begin
      if (cur_v && cur_f < lim) begin
        req.we = 1'b1;
        req.addr = {cur_m, cur_f[SlotW-1:0]};
      end else if (prev_v && prev_f == '0) begin
        req.we = 1'b1;
        req.addr = {prev_m, {SlotW{1'b0}}};
      end else if (32'(fcnt_q) < FullDepth) begin
        req.we = (ecnt_q != '0) || (32'(pool_q) < PoolMags);
        req.addr = (ecnt_q != '0)
                 ? {estk_q[EidxW'(ecnt_q - EcntW'(1))],
                    fill_q[estk_q[EidxW'(ecnt_q - EcntW'(1))]][SlotW-1:0]}
                 : {MagW'(pool_q), {SlotW{1'b0}}};
      end else if (cur_v && cur_f == '0) begin
        req.we = 1'b1;
        req.addr = {cur_m, {SlotW{1'b0}}};
      end
    end else if (state_q == S_DEC && out_free && op_q == OP_GET) begin
      if (cur_v && cur_f != '0) begin
        req.addr = {cur_m, SlotW'(cur_f - FillW'(1))};
      end else begin
        req.addr = {prev_m, SlotW'(prev_f - FillW'(1))};
      end
    end else if (state_q == S_FLRD) begin
      req.addr = {fmag_q, fidx_q[SlotW-1:0]};
    end else if (state_q == S_FLOUT && fidx_q + FillW'(1) == fcnt_walk_q) begin
      // after the walk the new handle goes to slot 0
      req.we = 1'b1;
      req.addr = {fmag_q, {SlotW{1'b0}}};
    end
  end

  // checks
  a_cnt_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fcnt_q) <= FullDepth) else $error("full stack overflow");
  a_cnt_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ecnt_q) <= EmptyDepth) else $error("empty stack overflow");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("accepted while busy");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped");
endmodule

>>> design/pcmc_ram.sv
// ============================================================================
// pcmc_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ============================================================================
module pcmc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
